// File: rtl/pdsc_pkg.sv
package pdsc_pkg;

  localparam int DataW = 16;
  localparam int CfgIdxW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegPropGain   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDerivGain  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGainDiv    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTrim       = 8'd3;
  localparam logic [CfgIdxW-1:0] RegCentre     = 8'd4;
  localparam logic [CfgIdxW-1:0] RegPulseMin   = 8'd5;
  localparam logic [CfgIdxW-1:0] RegPulseMax   = 8'd6;
  localparam logic [CfgIdxW-1:0] RegSlew       = 8'd7;

  // operation codes
  localparam logic OpUpdate = 1'b0;
  localparam logic OpSetRaw = 1'b1;

  // weighted sum magnitude width (two 16x16 products plus a carry)
  localparam int SumW = 33;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// File: rtl/pd_servo_pulse_controller.sv
// Channel  | Dir | Payload
// s_axis   | in  | tdata[15:0] deviation, [31:16] raw_pulse; tuser operation
// m_axis   | out | tdata[15:0] pulse, [31:16] drive_term
// cfg      | in  | cfg_index register index, cfg_data value
// An update passes through StMul (the products), StSum (the sum and divider
// start), StDiv (the serial divider, 33 quotient bits, one per cycle, then the
// saturated drive term), StSat (centre and trim added), StClmp (clamp) and
// StSlew (slew), where the result becomes valid. A set-raw item goes from
// acceptance straight to StClmp and StSlew. The next item can be accepted at the
// edge the result is taken. One item is in work at a time, and s_axis_tready stays low while
// a result waits on m_axis_tready. Reset (rst, synchronous) loads the register
// defaults.
module pd_servo_pulse_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // deviation, raw_pulse
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pulse, drive_term
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pdsc_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMul  = 7'b0000010,
    StSum  = 7'b0000100,
    StDiv  = 7'b0001000,
    StSat  = 7'b0010000,
    StClmp = 7'b0100000,
    StSlew = 7'b1000000
  } state_t;

  state_t state;

  logic signed [15:0] prop_gain, deriv_gain, trim_offset;
  logic [15:0] gain_divisor, pulse_centre, pulse_min, pulse_max, slew_limit;
  logic signed [15:0] prev_dev;
  logic [15:0] prev_pulse;
  logic signed [15:0] held_drive;

  logic        op;
  logic signed [15:0] dev, diffv;
  logic [15:0] raw;
  logic signed [31:0] prod_p, prod_d;
  logic        neg;
  logic [SumW-1:0] mag;
  logic signed [17:0] trim_use;
  logic signed [19:0] psum;
  logic [15:0] pclamp;

  div_ctl_t div_ctl;
  div_sts_t div_sts;
  logic [SumW-1:0] quo;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == StIdle) && !(m_axis_tvalid && !m_axis_tready);

  // trim clamp against current limits
  logic signed [17:0] hi_t, lo_t;
  assign hi_t = $signed({2'b00, pulse_max}) - $signed({2'b00, pulse_centre});
  assign lo_t = $signed({2'b00, pulse_min}) - $signed({2'b00, pulse_centre});

  function automatic logic [15:0] clampf(input logic signed [19:0] v,
                                         input logic [15:0] lo,
                                         input logic [15:0] hi);
    logic [15:0] r;
    if (v < $signed({4'b0, lo})) r = lo;
    else if (v > $signed({4'b0, hi})) r = hi;
    else r = v[15:0];
    return r;
  endfunction

  // weighted sum and its magnitude, taken by the divider at start
  logic signed [33:0] ssum;
  assign ssum = 34'(prod_p) + 34'(prod_d);
  assign mag = ssum[33] ? SumW'(-ssum) : ssum[SumW-1:0];
  assign div_ctl.start = (state == StSum);

  pdsc_divider u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl),
    .dividend(mag),
    .divisor(gain_divisor == 16'd0 ? 16'd1 : gain_divisor),
    .sts(div_sts), .quotient(quo)
  );

  logic signed [17:0] dlt;
  assign dlt = $signed({2'b00, pclamp}) - $signed({2'b00, prev_pulse});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      prop_gain    <= '0;
      deriv_gain   <= '0;
      gain_divisor <= 16'd10;
      trim_offset  <= '0;
      pulse_centre <= 16'd1500;
      pulse_min    <= 16'd1300;
      pulse_max    <= 16'd1700;
      slew_limit   <= '0;
      prev_dev     <= '0;
      prev_pulse   <= 16'd1500;
      held_drive   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegPropGain: prop_gain    <= cfg_data;
          RegDerivGain: deriv_gain  <= cfg_data;
          RegGainDiv:  gain_divisor <= cfg_data;
          RegTrim:     trim_offset  <= cfg_data;
          RegCentre:   pulse_centre <= cfg_data;
          RegPulseMin: pulse_min    <= cfg_data;
          RegPulseMax: pulse_max    <= cfg_data;
          RegSlew:     slew_limit   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          op  <= s_axis_tuser;
          dev <= s_axis_tdata[15:0];
          raw <= s_axis_tdata[31:16];
          diffv <= s_axis_tdata[15:0] - prev_dev;
          state <= (s_axis_tuser == OpSetRaw) ? StClmp : StMul;
        end
        StMul: begin
          prod_p <= prop_gain * dev;
          prod_d <= deriv_gain * diffv;
          prev_dev <= dev;
          state <= StSum;
        end
        StSum: begin
          neg <= ssum[33];
          state <= StDiv;
        end
        StDiv: begin
          if (!(hi_t < $signed(18'(trim_offset))) &&
              !(lo_t > $signed(18'(trim_offset))))
            trim_use <= 18'(trim_offset);
          else if (hi_t < $signed(18'(trim_offset))) trim_use <= hi_t;
          else trim_use <= lo_t;
          if (div_sts.done) begin
            if (!neg) held_drive <= (quo > SumW'(32767)) ? 16'sd32767 : quo[15:0];
            else held_drive <= (quo > SumW'(32768)) ? -16'sd32768 : 16'(-quo[15:0]);
            state <= StSat;
          end
        end
        StSat: begin
          psum <= $signed({4'b0, pulse_centre}) + 20'(trim_use) + 20'(held_drive);
          state <= StClmp;
        end
        StClmp: begin
          if (op == OpSetRaw) begin
            if (hi_t < $signed(18'(trim_offset))) trim_use <= hi_t;
            else if (lo_t > $signed(18'(trim_offset))) trim_use <= lo_t;
            else trim_use <= 18'(trim_offset);
            pclamp <= clampf({4'b0, raw}, pulse_min, pulse_max);
            prev_dev <= '0;
          end else begin
            pclamp <= clampf(psum, pulse_min, pulse_max);
          end
          state <= StSlew;
        end
        StSlew: begin
          if (op == OpSetRaw) begin
            prev_pulse <= pclamp;
            held_drive <= 16'(pclamp - pulse_centre - trim_use[15:0]);
          end else if (slew_limit != 16'd0 && dlt > $signed({2'b00, slew_limit})) begin
            prev_pulse <= prev_pulse + slew_limit;
          end else if (slew_limit != 16'd0 && dlt < -$signed({2'b00, slew_limit})) begin
            prev_pulse <= prev_pulse - slew_limit;
          end else begin
            prev_pulse <= pclamp;
          end
          m_axis_tvalid <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = {held_drive, prev_pulse};

endmodule

// File: rtl/pdsc_divider.sv
module pdsc_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  pdsc_pkg::div_ctl_t             ctl,
  input  logic [pdsc_pkg::SumW-1:0]      dividend,
  input  logic [pdsc_pkg::DataW-1:0]     divisor,
  output pdsc_pkg::div_sts_t             sts,
  output logic [pdsc_pkg::SumW-1:0]      quotient
);
  import pdsc_pkg::*;

  localparam int CntW = $clog2(SumW + 1);

  // restoring divide, one quotient bit per cycle
  logic [SumW-1:0]  quo;
  logic [DataW:0]   rem;
  logic [DataW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic [DataW:0]   trial;
  logic [DataW+1:0] diff;

  assign trial = {rem[DataW-1:0], quo[SumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(SumW);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[DataW+1]) begin
          rem <= diff[DataW:0];
          quo <= {quo[SumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[SumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: tb/pd_servo_pulse_controller_tb.sv
module pd_servo_pulse_controller_tb;
  import pdsc_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 60;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // deviation, raw_pulse
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // pulse, drive_term
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  pd_servo_pulse_controller uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // servo register shadow
  logic signed [15:0] kp_q, kd_q, trim_q;
  logic [15:0] div_q, centre_q, min_q, max_q, slew_q;
  // loop state shadow
  logic signed [15:0] last_dev_q, drive_q;
  logic [15:0] last_pulse_q;

  logic [31:0] pulse_expect_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit allow_idle = 1;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_to_limits(longint p);
    if (p < longint'(min_q)) return longint'(min_q);
    else if (p > longint'(max_q)) return longint'(max_q);
    return p;
  endfunction

  function automatic longint trim_now();
    longint hi, lo, t;
    hi = longint'(max_q) - longint'(centre_q);
    lo = longint'(min_q) - longint'(centre_q);
    t = trim_q;
    if (t > hi) t = hi;
    else if (t < lo) t = lo;
    return t;
  endfunction

  // predict one transaction and queue the expected result
  task automatic predict_pulse(logic op, logic signed [15:0] dev, logic [15:0] raw);
    longint trim, sum, q, p, dv;
    logic signed [15:0] diff;
    trim = trim_now();
    if (op == OpUpdate) begin
      diff = dev - last_dev_q;
      last_dev_q = dev;
      dv = (div_q == 0) ? 1 : longint'(div_q);
      sum = longint'(kp_q) * dev + longint'(kd_q) * diff;
      q = sum / dv;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      drive_q = q[15:0];
      p = clamp_to_limits(longint'(centre_q) + trim + q);
      if (slew_q != 0) begin
        if (p - longint'(last_pulse_q) > longint'(slew_q))
          p = longint'(last_pulse_q) + slew_q;
        else if (p - longint'(last_pulse_q) < -longint'(slew_q))
          p = longint'(last_pulse_q) - slew_q;
      end
      last_pulse_q = p[15:0];
    end else begin
      p = clamp_to_limits(longint'(raw));
      last_pulse_q = p[15:0];
      last_dev_q = 0;
      sum = longint'(last_pulse_q) - longint'(centre_q) - trim;
      drive_q = sum[15:0];
    end
    pulse_expect_q.push_back({drive_q, last_pulse_q});
  endtask

  // tvalid stays up after acceptance; here it drops only before an idle gap (wait_idle also drops it)
  task automatic send_item(logic op, logic [15:0] dev, logic [15:0] raw);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {raw, dev};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pulse(op, dev, raw);
    sent++;
  endtask

  // cfg_valid stays up across back-to-back writes; load_setup drops it
  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegPropGain:  kp_q = val;
      RegDerivGain: kd_q = val;
      RegGainDiv:   div_q = val;
      RegTrim:      trim_q = val;
      RegCentre:    centre_q = val;
      RegPulseMin:  min_q = val;
      RegPulseMax:  max_q = val;
      RegSlew:      slew_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pulse_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_setup(logic [15:0] kp, logic [15:0] kd, logic [15:0] dv,
                            logic [15:0] tr, logic [15:0] ce, logic [15:0] mn,
                            logic [15:0] mx, logic [15:0] sl);
    wait_idle();
    write_reg(RegPropGain, kp);
    write_reg(RegDerivGain, kd);
    write_reg(RegGainDiv, dv);
    write_reg(RegTrim, tr);
    write_reg(RegCentre, ce);
    write_reg(RegPulseMin, mn);
    write_reg(RegPulseMax, mx);
    write_reg(RegSlew, sl);
    cfg_valid <= 1'b0;
  endtask

  // directed: field extremes, both operations, reset defaults
  task automatic test_directed();
    send_item(OpUpdate, 16'h1234, 16'h0);
    load_setup(16'sd100, -16'sd50, 16'd10, 16'sd0, 16'd1500, 16'd1300, 16'd1700, 16'd0);
    send_item(OpUpdate, 16'h7FFF, 16'h0);
    send_item(OpUpdate, 16'h8000, 16'h0);   // wrapped difference
    send_item(OpUpdate, 16'h0000, 16'hFFFF);
    send_item(OpSetRaw, 16'hFFFF, 16'hFFFF);
    send_item(OpSetRaw, 16'h0, 16'h0000);
    send_item(OpSetRaw, 16'h0, 16'd1550);
    send_item(OpUpdate, 16'd5, 16'h0);
    // gains at full scale, divisor 1: saturation both ways
    load_setup(16'sd32767, 16'sd32767, 16'd1, 16'sd0, 16'd30000, 16'd0, 16'd65535, 16'd0);
    send_item(OpUpdate, 16'h7FFF, 16'h0);
    send_item(OpUpdate, 16'h8000, 16'h0);
    send_item(OpUpdate, 16'h8000, 16'h0);
    // zero divisor with trim clamped high, then divisor 65535 with trim clamped low
    load_setup(-16'sd32767, 16'sd1, 16'd0, 16'sh7FFF, 16'd1000, 16'd900, 16'd1100, 16'd0);
    send_item(OpUpdate, 16'd3, 16'h0);
    send_item(OpSetRaw, 16'h0, 16'd1050);
    load_setup(16'sd7, -16'sd32767, 16'd65535, 16'sh8000, 16'd1000, 16'd900, 16'd1100, 16'd5);
    send_item(OpUpdate, 16'd300, 16'h0);
    send_item(OpUpdate, -16'sd300, 16'h0);
    send_item(OpSetRaw, 16'h0, 16'd2000);
    // min above max: min is checked first, so values below min take min, the rest take max
    load_setup(16'sd3, 16'sd0, 16'd1, 16'sd0, 16'd500, 16'd600, 16'd400, 16'd65535);
    send_item(OpUpdate, 16'd10, 16'h0);
    send_item(OpSetRaw, 16'h0, 16'd0);
    send_item(OpSetRaw, 16'h0, 16'd1000);
  endtask

  task automatic random_setup();
    logic [15:0] a, b;
    a = $urandom;
    b = $urandom;
    if ($urandom_range(0, 3) != 0 && a > b) {a, b} = {b, a};
    load_setup($urandom_range(0, 65534) - 16'd32767 + 16'd0 == 16'h8000 ? 16'd1 :
               16'($urandom_range(0, 65534) - 32767),
               16'($urandom_range(0, 65534) - 32767),
               $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300)),
               16'($urandom), 16'($urandom), a, b,
               $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
  endtask

  // random: loop tracking with random content, occasional raw overrides
  task automatic test_random(int phases, int per_phase);
    logic [15:0] dev;
    for (int ph = 0; ph < phases; ph++) begin
      random_setup();
      dev = $urandom;
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(0, 5))
          0: send_item(OpSetRaw, 16'($urandom), 16'($urandom));
          1: send_item(OpUpdate, 16'($urandom), 16'($urandom));
          default: begin
            dev = dev + 16'($signed($urandom_range(0, 200)) - 100);
            send_item(OpUpdate, dev, 16'($urandom));
          end
        endcase
      end
    end
  endtask

  // receiver stalls long while sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_item(OpUpdate, 16'($urandom), 16'h0);
    join
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OpUpdate;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    kp_q = 0; kd_q = 0; div_q = 10; trim_q = 0;
    centre_q = 1500; min_q = 1300; max_q = 1700; slew_q = 0;
    last_dev_q = 0; drive_q = 0; last_pulse_q = 1500;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(14, 45);
    allow_idle = 0;
    test_random(2, 30);
    wait_idle();
    $display("Sent %0d items across directed, stall and random register settings;", sent);
    $display("checked %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("pd_servo_pulse_controller_tb: PASS");
    end else begin
      $display("pd_servo_pulse_controller_tb: FAIL");
    end
    $finish;
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    int burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (allow_idle && burst == 0 && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= (burst == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [31:0] exp_word;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked++;
      if (pulse_expect_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_word = pulse_expect_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_word[15:0]) begin
          $error("pulse: expected %0d, got %0d", exp_word[15:0], m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== exp_word[31:16]) begin
          $error("drive_term: expected %0d, got %0d",
                 $signed(exp_word[31:16]), $signed(m_axis_tdata[31:16]));
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("pd_servo_pulse_controller_tb: FAIL");
        $finish;
      end
    end
  end
endmodule

// File: pd_servo_pulse_controller.f
rtl/pdsc_pkg.sv
rtl/pdsc_divider.sv
rtl/pd_servo_pulse_controller.sv
tb/pd_servo_pulse_controller_tb.sv
